// ----- hdl/qri_pkg.sv -----
// ---------------------------------------------------------------------------
// qri_pkg: shared types and constants for the quaternion rate integrator
// Widths, controller commands, state encoding and the product term decoder.
// ---------------------------------------------------------------------------
package qri_pkg;

   localparam int QW       = 32;   // quaternion and rate field width
   localparam int TSW      = 24;   // time step width
   localparam int SW       = 42;   // derivative sum width
   localparam int AW       = 68;   // increment accumulator width
   localparam int IW       = 43;   // increment width
   localparam int MW       = 44;   // magnitude width before scaling
   localparam int QUOW     = 31;   // quotient width

   localparam logic signed [QW-1:0] ONE_Q30  = 32'sh4000_0000;
   localparam logic [TSW-1:0]       TS_RESET = 24'd33554;

   // request operation codes
   localparam logic REQ_INTEGRATE = 1'b0;
   localparam logic REQ_LOAD      = 1'b1;

   localparam logic [5:0] PROD_STEPS = 6'd12;
   localparam logic [5:0] INCR_STEPS = 6'd8;
   localparam logic [5:0] SQ_STEPS   = 6'd4;
   localparam logic [5:0] SQRT_LAST  = 6'd31;
   localparam logic [5:0] DIV_LAST   = 6'd30;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_PROD,
      OP_INCR,
      OP_VEC,
      OP_SHR,
      OP_SHL,
      OP_SQ,
      OP_ROOT,
      OP_SQRT,
      OP_DINIT,
      OP_DIV,
      OP_WRQ,
      OP_WRID,
      OP_OUT
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_INCR,
      ST_VEC,
      ST_SHIFT,
      ST_SQ,
      ST_ROOT,
      ST_SQRT,
      ST_DINIT,
      ST_DIV,
      ST_WRQ,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] idx;
   } cmd_type;

   typedef struct packed {
      logic zero;
      logic shr;
      logic shl;
   } status_type;

   typedef struct packed {
      logic [1:0] qa;
      logic [1:0] wb;
      logic [1:0] tgt;
      logic       sub;
   } term_type;

   // one product of the quaternion derivative per step
   function automatic term_type prod_term(input logic [3:0] k);
      term_type t;
      unique case (k)
         4'd0:    t = '{qa: 2'd1, wb: 2'd0, tgt: 2'd0, sub: 1'b1};
         4'd1:    t = '{qa: 2'd2, wb: 2'd1, tgt: 2'd0, sub: 1'b1};
         4'd2:    t = '{qa: 2'd3, wb: 2'd2, tgt: 2'd0, sub: 1'b1};
         4'd3:    t = '{qa: 2'd0, wb: 2'd0, tgt: 2'd1, sub: 1'b0};
         4'd4:    t = '{qa: 2'd2, wb: 2'd2, tgt: 2'd1, sub: 1'b0};
         4'd5:    t = '{qa: 2'd3, wb: 2'd1, tgt: 2'd1, sub: 1'b1};
         4'd6:    t = '{qa: 2'd0, wb: 2'd1, tgt: 2'd2, sub: 1'b0};
         4'd7:    t = '{qa: 2'd1, wb: 2'd2, tgt: 2'd2, sub: 1'b1};
         4'd8:    t = '{qa: 2'd3, wb: 2'd0, tgt: 2'd2, sub: 1'b0};
         4'd9:    t = '{qa: 2'd0, wb: 2'd2, tgt: 2'd3, sub: 1'b0};
         4'd10:   t = '{qa: 2'd1, wb: 2'd1, tgt: 2'd3, sub: 1'b0};
         4'd11:   t = '{qa: 2'd2, wb: 2'd0, tgt: 2'd3, sub: 1'b1};
         default: t = '{qa: 2'd0, wb: 2'd0, tgt: 2'd0, sub: 1'b0};
      endcase
      return t;
   endfunction

endpackage

// ----- hdl/qri_chan_if.sv -----
// ---------------------------------------------------------------------------
// qri channel interfaces
// Request, response and time step write channels with valid/ready.
// ---------------------------------------------------------------------------
interface qri_req_if import qri_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic signed [QW-1:0] rate_x;
   logic signed [QW-1:0] rate_y;
   logic signed [QW-1:0] rate_z;
   logic signed [QW-1:0] load_w;
   logic signed [QW-1:0] load_x;
   logic signed [QW-1:0] load_y;
   logic signed [QW-1:0] load_z;
   modport source (output valid, operation, rate_x, rate_y, rate_z,
                   load_w, load_x, load_y, load_z, input ready);
   modport sink   (input valid, operation, rate_x, rate_y, rate_z,
                   load_w, load_x, load_y, load_z, output ready);
endinterface

interface qri_rsp_if import qri_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic signed [QW-1:0] att_w;
   logic signed [QW-1:0] att_x;
   logic signed [QW-1:0] att_y;
   logic signed [QW-1:0] att_z;
   logic                 zero_norm;
   modport source (output valid, att_w, att_x, att_y, att_z, zero_norm, input ready);
   modport sink   (input valid, att_w, att_x, att_y, att_z, zero_norm, output ready);
endinterface

interface qri_csr_if import qri_pkg::*; ();
   logic           valid;
   logic           ready;
   logic [TSW-1:0] time_step;
   modport source (output valid, time_step, input ready);
   modport sink   (input valid, time_step, output ready);
endinterface

// ----- hdl/qri_ctrl.sv -----
// ---------------------------------------------------------------------------
// qri_ctrl: sequencer for the quaternion rate integrator
// Steps the datapath through products, increment, scaling, root and divide.
// ---------------------------------------------------------------------------
module qri_ctrl import qri_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_operation,
   output logic       req_ready,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   input  status_type status,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '{op: OP_NONE, idx: cnt_ff[3:0]};
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cnt_in    = '0;
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = (req_operation == REQ_LOAD) ? ST_DONE : ST_PROD;
            end
         end
         ST_PROD: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff < PROD_STEPS) begin
               cmd.op = OP_PROD;
            end else begin
               // last product drains through the accumulator here
               cnt_in   = '0;
               state_in = ST_INCR;
            end
         end
         ST_INCR: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff < INCR_STEPS) begin
               cmd.op = OP_INCR;
            end else begin
               cnt_in   = '0;
               state_in = ST_VEC;
            end
         end
         ST_VEC: begin
            cmd.op   = OP_VEC;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (status.zero) begin
               cmd.op   = OP_WRID;
               state_in = ST_DONE;
            end else if (status.shr) begin
               cmd.op = OP_SHR;
            end else if (status.shl) begin
               cmd.op = OP_SHL;
            end else begin
               cnt_in   = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff < SQ_STEPS) begin
               cmd.op = OP_SQ;
            end else begin
               cnt_in   = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            cmd.op   = OP_ROOT;
            cnt_in   = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.op = OP_SQRT;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == SQRT_LAST) begin
               state_in = ST_DINIT;
            end
         end
         ST_DINIT: begin
            cmd.op   = OP_DINIT;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = OP_DIV;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_WRQ;
            end
         end
         ST_WRQ: begin
            cmd.op   = OP_WRQ;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register can take the result
            if (out_free) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/qri_datapath.sv -----
// ---------------------------------------------------------------------------
// qri_datapath: arithmetic of the quaternion rate integrator
// Shared multiplier, accumulators, scaling shifter, root and four dividers.
// ---------------------------------------------------------------------------
module qri_datapath import qri_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic                 req_operation,
   input  logic signed [QW-1:0] req_rate_x,
   input  logic signed [QW-1:0] req_rate_y,
   input  logic signed [QW-1:0] req_rate_z,
   input  logic signed [QW-1:0] req_load_w,
   input  logic signed [QW-1:0] req_load_x,
   input  logic signed [QW-1:0] req_load_y,
   input  logic signed [QW-1:0] req_load_z,
   input  logic                 csr_write,
   input  logic [TSW-1:0]       csr_time_step,
   output logic signed [QW-1:0] rsp_att_w,
   output logic signed [QW-1:0] rsp_att_x,
   output logic signed [QW-1:0] rsp_att_y,
   output logic signed [QW-1:0] rsp_att_z,
   output logic                 rsp_zero_norm
);

   logic signed [QW-1:0]   q_ff [4];
   logic [TSW-1:0]         ts_ff;
   logic                   flag_ff;
   cmd_type                dly_ff;

   logic signed [QW-1:0]   w_ff [3];
   logic signed [2*QW-1:0] prod_ff;
   logic signed [SW-1:0]   s_ff [4];
   logic signed [AW-1:0]   acc_ff;
   logic signed [IW-1:0]   inc_ff [4];
   logic [MW-1:0]          mag_ff [4];
   logic                   neg_ff [4];
   logic [63:0]            sum_ff;
   logic [63:0]            rem_ff, res_ff, bit_ff;
   logic [QW-1:0]          drem_ff [4];
   logic [QUOW-1:0]        dnum_ff [4];
   logic [QUOW-1:0]        quo_ff [4];
   logic signed [QW-1:0]   att_ff [4];
   logic                   zero_ff;

   logic signed [QW-1:0]   mul_a, mul_b;
   logic signed [2*QW-1:0] mul_p;
   term_type               term_c, term_d;
   logic signed [SW-1:0]   s_sel;
   logic signed [SW-1:0]   p_floor;
   logic signed [AW-1:0]   acc_sum;
   logic [63:0]            root_try;
   logic [QW-1:0]          n_val;

   assign term_c  = prod_term(cmd.idx);
   assign term_d  = prod_term(dly_ff.idx);
   assign s_sel   = s_ff[cmd.idx[2:1]];
   assign p_floor = SW'(prod_ff >>> 24);
   assign acc_sum = acc_ff + AW'(prod_ff);
   assign root_try = res_ff + bit_ff;
   assign n_val   = res_ff[QW-1:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_PROD: begin
            mul_a = q_ff[term_c.qa];
            mul_b = w_ff[term_c.wb];
         end
         OP_INCR: begin
            // split the sum into a signed high part and an unsigned low part
            mul_a = cmd.idx[0] ? $signed({11'b0, s_sel[20:0]}) : QW'(s_sel >>> 21);
            mul_b = $signed({8'b0, ts_ff});
         end
         OP_SQ: begin
            mul_a = $signed({1'b0, mag_ff[cmd.idx[1:0]][QW-2:0]});
            mul_b = mul_a;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      status.zero = 1'b1;
      status.shr  = 1'b0;
      status.shl  = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (mag_ff[i] != '0) status.zero = 1'b0;
         if (mag_ff[i][MW-1:31] != '0) status.shr = 1'b1;
         if (mag_ff[i][MW-1:30] != '0) status.shl = 1'b0;
      end
      status.shl = status.shl && !status.zero;
   end

   // state, time step and control
   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff[0] <= ONE_Q30;
         q_ff[1] <= '0;
         q_ff[2] <= '0;
         q_ff[3] <= '0;
         ts_ff   <= TS_RESET;
         flag_ff <= 1'b0;
         dly_ff  <= '{op: OP_NONE, idx: 4'd0};
      end else begin
         dly_ff <= cmd;
         if (csr_write) begin
            ts_ff <= csr_time_step;
         end
         case (cmd.op)
            OP_ACCEPT: begin
               flag_ff <= 1'b0;
               if (req_operation == REQ_LOAD) begin
                  q_ff[0] <= req_load_w;
                  q_ff[1] <= req_load_x;
                  q_ff[2] <= req_load_y;
                  q_ff[3] <= req_load_z;
               end
            end
            OP_WRQ: begin
               for (int i = 0; i < 4; i++) begin
                  q_ff[i] <= neg_ff[i] ? -$signed({1'b0, quo_ff[i]})
                                       : $signed({1'b0, quo_ff[i]});
               end
               flag_ff <= 1'b0;
            end
            OP_WRID: begin
               q_ff[0] <= ONE_Q30;
               q_ff[1] <= '0;
               q_ff[2] <= '0;
               q_ff[3] <= '0;
               flag_ff <= 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      case (cmd.op)
         OP_ACCEPT: begin
            w_ff[0] <= req_rate_x;
            w_ff[1] <= req_rate_y;
            w_ff[2] <= req_rate_z;
            for (int i = 0; i < 4; i++) s_ff[i] <= '0;
         end
         OP_VEC: begin
            for (int i = 0; i < 4; i++) begin
               logic signed [MW-1:0] v;
               v = MW'(q_ff[i]) + MW'(inc_ff[i]);
               neg_ff[i] <= v[MW-1];
               mag_ff[i] <= v[MW-1] ? MW'(-v) : MW'(v);
            end
            sum_ff <= '0;
         end
         OP_SHR: begin
            for (int i = 0; i < 4; i++) mag_ff[i] <= mag_ff[i] >> 1;
         end
         OP_SHL: begin
            for (int i = 0; i < 4; i++) mag_ff[i] <= mag_ff[i] << 1;
         end
         OP_ROOT: begin
            rem_ff <= sum_ff;
            res_ff <= '0;
            bit_ff <= 64'h4000_0000_0000_0000;
         end
         OP_SQRT: begin
            if (rem_ff >= root_try) begin
               rem_ff <= rem_ff - root_try;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         OP_DINIT: begin
            for (int i = 0; i < 4; i++) begin
               logic [61:0] num;
               num = {1'b0, mag_ff[i][QUOW-1:0], 30'b0} + 62'(n_val >> 1);
               drem_ff[i] <= {1'b0, num[61:31]};
               dnum_ff[i] <= num[30:0];
               quo_ff[i]  <= '0;
            end
         end
         OP_DIV: begin
            for (int i = 0; i < 4; i++) begin
               logic [QW:0] t;
               logic        ge;
               t  = {drem_ff[i], dnum_ff[i][QUOW-1]};
               ge = t >= {1'b0, n_val};
               drem_ff[i] <= ge ? QW'(t - {1'b0, n_val}) : t[QW-1:0];
               quo_ff[i]  <= {quo_ff[i][QUOW-2:0], ge};
               dnum_ff[i] <= dnum_ff[i] << 1;
            end
         end
         OP_OUT: begin
            for (int i = 0; i < 4; i++) att_ff[i] <= q_ff[i];
            zero_ff <= flag_ff;
         end
         default: begin
         end
      endcase

      // accumulate the registered product of the command held in dly_ff
      case (dly_ff.op)
         OP_PROD: begin
            s_ff[term_d.tgt] <= term_d.sub ? s_ff[term_d.tgt] - p_floor
                                           : s_ff[term_d.tgt] + p_floor;
         end
         OP_INCR: begin
            if (dly_ff.idx[0]) begin
               inc_ff[dly_ff.idx[2:1]] <= IW'(acc_sum >>> 25);
            end else begin
               acc_ff <= AW'(prod_ff) <<< 21;
            end
         end
         OP_SQ: begin
            sum_ff <= sum_ff + 64'(prod_ff);
         end
         default: begin
         end
      endcase
   end

   assign rsp_att_w     = att_ff[0];
   assign rsp_att_x     = att_ff[1];
   assign rsp_att_y     = att_ff[2];
   assign rsp_att_z     = att_ff[3];
   assign rsp_zero_norm = zero_ff;

endmodule

// ----- hdl/quaternion_rate_integrator_unit.sv -----
// ---------------------------------------------------------------------------
// quaternion_rate_integrator_unit: attitude quaternion Euler integrator
// Keeps a Q1.30 attitude quaternion, integrates body rates and renormalizes.
// ---------------------------------------------------------------------------
// A load request goes from acceptance straight to the result. An integrate
// request runs products, increment, a scaling shift of 0 to 30 bits, then
// square, root and divide; one whose integrated quaternion is all zero
// returns the identity instead. The work runs on the single shared 32x32
// multiplier (12 products, 8 increment partials, 4 squares), the 32-step
// bit-serial square root and the 31-step dividers that run in four lanes
// side by side. One request is in work at a time; a new request is accepted
// while the previous result still waits in the output register. The time
// step register may be written at any time the block is idle.
module quaternion_rate_integrator_unit import qri_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   qri_req_if.sink      req_bus,
   qri_rsp_if.source    rsp_bus,
   qri_csr_if.sink      csr_bus
);

   cmd_type    cmd;
   status_type status;

   assign csr_bus.ready = 1'b1;

   qri_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_operation (req_bus.operation),
      .req_ready     (req_bus.ready),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .status        (status),
      .cmd           (cmd)
   );

   qri_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_operation (req_bus.operation),
      .req_rate_x    (req_bus.rate_x),
      .req_rate_y    (req_bus.rate_y),
      .req_rate_z    (req_bus.rate_z),
      .req_load_w    (req_bus.load_w),
      .req_load_x    (req_bus.load_x),
      .req_load_y    (req_bus.load_y),
      .req_load_z    (req_bus.load_z),
      .csr_write     (csr_bus.valid && csr_bus.ready),
      .csr_time_step (csr_bus.time_step),
      .rsp_att_w     (rsp_bus.att_w),
      .rsp_att_x     (rsp_bus.att_x),
      .rsp_att_y     (rsp_bus.att_y),
      .rsp_att_z     (rsp_bus.att_z),
      .rsp_zero_norm (rsp_bus.zero_norm)
   );

   // one request in work at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted while another is in work");

   // a zero norm result carries the identity quaternion
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.zero_norm) |->
         (rsp_bus.att_w == ONE_Q30 && rsp_bus.att_x == '0 &&
          rsp_bus.att_y == '0 && rsp_bus.att_z == '0))
      else $error("zero norm flag without identity attitude");

   // a result appears only after a request was taken
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> !$past(req_bus.ready))
      else $error("result raised while the block was idle");

endmodule

// ----- bench/qri_att_checker.sv -----
// ---------------------------------------------------------------------------
// qri_att_checker: attitude predictor and response scoreboard
// Watches the request, response and time step channels, predicts each new
// attitude quaternion and compares every response field by field.
// ---------------------------------------------------------------------------
module qri_att_checker import qri_pkg::*; #(
   parameter logic LOAD_OP = REQ_LOAD
) (
   input  logic clock,
   input  logic reset,
   qri_req_if   req,
   qri_rsp_if   rsp,
   qri_csr_if   csr,
   output int   fail_count,
   output int   pending
);

   typedef struct {
      logic signed [QW-1:0] w, x, y, z;
      logic                 zero_norm;
   } att_result_type;

   att_result_type   att_expected_q[$];
   longint           att_q[4];
   logic [TSW-1:0]   step_size;

   function automatic logic [63:0] root_floor(logic [63:0] x);
      logic [63:0] rem, res, bit_w;
      rem = x;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > x) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (rem >= res + bit_w) begin
            rem = rem - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   function automatic longint prod_q30(longint a, longint b);
      longint p;
      p = a * b;
      return p >>> 24;
   endfunction

   // one Euler step plus renormalization; updates att_q, returns the flag
   function automatic logic integrate_step(longint wx, longint wy, longint wz);
      longint               s[4], v[4];
      logic signed [127:0]  scaled;
      logic [63:0]          mag[4], mx, sum, n, r;
      logic                 neg[4];
      int                   rs, ls;
      s[0] = -(prod_q30(att_q[1], wx) + prod_q30(att_q[2], wy) + prod_q30(att_q[3], wz));
      s[1] = prod_q30(att_q[0], wx) + prod_q30(att_q[2], wz) - prod_q30(att_q[3], wy);
      s[2] = prod_q30(att_q[0], wy) - prod_q30(att_q[1], wz) + prod_q30(att_q[3], wx);
      s[3] = prod_q30(att_q[0], wz) + prod_q30(att_q[1], wy) - prod_q30(att_q[2], wx);
      mx = 0;
      for (int i = 0; i < 4; i++) begin
         scaled = 128'(signed'(s[i])) * signed'({104'd0, step_size});
         scaled = scaled >>> 25;
         v[i] = att_q[i] + longint'(scaled);
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? 64'(-v[i]) : 64'(v[i]);
         if (mag[i] > mx) mx = mag[i];
      end
      if (mx == 0) begin
         att_q = '{64'sd1 << 30, 0, 0, 0};
         return 1'b1;
      end
      rs = 0;
      ls = 0;
      while ((mx >> rs) >= (64'd1 << 31)) rs++;
      while (rs == 0 && (mx << ls) < (64'd1 << 30)) ls++;
      sum = 0;
      for (int i = 0; i < 4; i++) begin
         mag[i] = (mag[i] >> rs) << ls;
         sum = sum + mag[i] * mag[i];
      end
      n = root_floor(sum);
      for (int i = 0; i < 4; i++) begin
         r = ((mag[i] << 30) + (n >> 1)) / n;
         att_q[i] = neg[i] ? -longint'(r) : longint'(r);
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      att_result_type e;
      if (reset) begin
         att_q = '{64'sd1 << 30, 0, 0, 0};
         step_size = TS_RESET;
         att_expected_q.delete();
         fail_count = 0;
      end else begin
         if (csr.valid && csr.ready) step_size = csr.time_step;
         if (req.valid && req.ready) begin
            e.zero_norm = 1'b0;
            if (req.operation == LOAD_OP) begin
               att_q = '{longint'(req.load_w), longint'(req.load_x),
                         longint'(req.load_y), longint'(req.load_z)};
            end else begin
               e.zero_norm = integrate_step(longint'(req.rate_x), longint'(req.rate_y),
                                            longint'(req.rate_z));
            end
            e.w = att_q[0][QW-1:0];
            e.x = att_q[1][QW-1:0];
            e.y = att_q[2][QW-1:0];
            e.z = att_q[3][QW-1:0];
            att_expected_q.push_back(e);
         end
         if (rsp.valid && rsp.ready) begin
            if (att_expected_q.size() == 0) begin
               $error("unexpected response w=%h x=%h y=%h z=%h", rsp.att_w, rsp.att_x,
                      rsp.att_y, rsp.att_z);
               fail_count++;
            end else begin
               e = att_expected_q.pop_front();
               if (rsp.att_w !== e.w) begin
                  $error("att_w expected %h actual %h", e.w, rsp.att_w); fail_count++;
               end
               if (rsp.att_x !== e.x) begin
                  $error("att_x expected %h actual %h", e.x, rsp.att_x); fail_count++;
               end
               if (rsp.att_y !== e.y) begin
                  $error("att_y expected %h actual %h", e.y, rsp.att_y); fail_count++;
               end
               if (rsp.att_z !== e.z) begin
                  $error("att_z expected %h actual %h", e.z, rsp.att_z); fail_count++;
               end
               if (rsp.zero_norm !== e.zero_norm) begin
                  $error("zero_norm expected %b actual %b", e.zero_norm, rsp.zero_norm);
                  fail_count++;
               end
            end
         end
      end
      pending = att_expected_q.size();
   end

endmodule

// ----- bench/tb_quaternion_rate_integrator_unit.sv -----
// ---------------------------------------------------------------------------
// tb_quaternion_rate_integrator_unit: attitude integrator regression
// Drives directed and random load/integrate requests over several time step
// settings with random stalls on both sides; the checker scores responses.
// ---------------------------------------------------------------------------
module tb_quaternion_rate_integrator_unit import qri_pkg::*; ();

   localparam int   SETTLE       = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending;
   int   rsp_hold = 0;
   bit   rsp_stall_on = 1'b1;
   bit   req_gap_on = 1'b1;

   qri_req_if req_bus ();
   qri_rsp_if rsp_bus ();
   qri_csr_if csr_bus ();

   quaternion_rate_integrator_unit u_dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus)
   );

   qri_att_checker #(.LOAD_OP(REQ_LOAD)) u_chk (
      .clock(clock), .reset(reset), .req(req_bus), .rsp(rsp_bus), .csr(csr_bus),
      .fail_count(fail_count), .pending(pending)
   );

   always #5 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.operation = REQ_INTEGRATE;
      req_bus.rate_x = '0; req_bus.rate_y = '0; req_bus.rate_z = '0;
      req_bus.load_w = '0; req_bus.load_x = '0; req_bus.load_y = '0; req_bus.load_z = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.time_step = '0;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(60, 15);
   endfunction

   // random back-pressure on responses: mostly short stalls, a few long ones
   always @(posedge clock) begin
      if (rsp_hold > 0) rsp_hold--;
      else if (rsp_stall_on) rsp_hold = gap_len();
      rsp_bus.ready <= !rsp_stall_on || (rsp_hold == 0);
   end

   function automatic logic signed [QW-1:0] pick_rate();
      int r;
      r = $urandom_range(9);
      if (r < 6) return $signed($urandom_range(2 * 67108864)) - 67108864;
      if (r < 8) return $signed($urandom_range(2 * 1048576)) - 1048576;
      return $urandom;
   endfunction

   task automatic send(logic op, logic signed [QW-1:0] a, b, c, d);
      int gap;
      req_bus.operation <= op;
      // put noise in the unused rate_x or load_w field; the other unused fields repeat the operands
      req_bus.rate_x <= (op == REQ_INTEGRATE) ? a : $signed($urandom);
      req_bus.rate_y <= b; req_bus.rate_z <= c;
      req_bus.load_w <= (op == REQ_INTEGRATE) ? $signed($urandom) : a;
      req_bus.load_x <= b; req_bus.load_y <= c; req_bus.load_z <= d;
      req_bus.valid <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      gap = req_gap_on ? gap_len() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_step(logic [TSW-1:0] val);
      csr_bus.time_step <= val;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic random_items(int count);
      logic [31:0] q;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) drain();
         if ($urandom_range(99) < 12) begin
            q = ($urandom_range(3) == 0) ? 32'($urandom) : 32'($urandom_range(32'h7FFF_FFFF));
            send(REQ_LOAD, $signed(q), $urandom, $urandom, $urandom);
         end else begin
            send(REQ_INTEGRATE, pick_rate(), pick_rate(), pick_rate(), '0);
         end
      end
   endtask

   logic [TSW-1:0] step_plan[5] = '{24'd16777215, 24'd1, 24'd0, 24'd4000000, TS_RESET};

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: default step, extremes of load and rate fields
      send(REQ_INTEGRATE, 32'sh0100_0000, 32'sh0, 32'sh0, '0);
      send(REQ_LOAD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send(REQ_INTEGRATE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0);
      send(REQ_LOAD, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send(REQ_INTEGRATE, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, '0);
      send(REQ_LOAD, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
      send(REQ_INTEGRATE, 32'sh1234_5678, -32'sh0765_4321, 32'sh7FFF_FFFF, '0);
      send(REQ_LOAD, 32'sh0000_0001, 32'sh0, 32'sh0, -32'sh1);
      send(REQ_INTEGRATE, 32'sh0, 32'sh0, 32'sh0, '0);
      send(REQ_LOAD, 32'sh4000_0000, 32'sh0, 32'sh0, 32'sh0);
      send(REQ_INTEGRATE, -32'sh0400_0000, 32'sh0200_0000, -32'sh0100_0000, '0);
      send(REQ_INTEGRATE, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, '0);
      drain();
      random_items(100);
      foreach (step_plan[k]) begin
         drain();
         write_step(step_plan[k]);
         rsp_stall_on = (k != 1);
         req_gap_on = (k != 3);
         if (step_plan[k] == 24'd0) begin
            send(REQ_LOAD, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
            send(REQ_INTEGRATE, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0100_0000, '0);
            send(REQ_LOAD, 32'sh3000_0000, -32'sh1000_0000, 32'sh0800_0000, 32'sh0);
         end
         random_items(80);
      end
      rsp_stall_on = 1'b1;
      drain();
      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #50000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/qri_pkg.sv
hdl/qri_chan_if.sv
hdl/qri_ctrl.sv
hdl/qri_datapath.sv
hdl/quaternion_rate_integrator_unit.sv
bench/qri_att_checker.sv
bench/tb_quaternion_rate_integrator_unit.sv
